>>> hdl/pee_pkg.sv
// Shared constants, codes and types of the Pauli expectation engine.
// No dependencies; every other file in hdl/ but pee_queue refers to this package.
`timescale 1ns / 1ps

package pee_pkg;

  // defaults for the top-level parameters
  localparam int MAX_QUBITS_DEF = 10;
  localparam int AMP_BITS_DEF   = 16;

  // qubit-count register
  localparam int NUM_QUBITS_W   = 4;
  localparam int NUM_QUBITS_RST = 10;

  // fixed-point formats
  localparam int FRAC_OUT = 30;   // fraction bits of every rescaled product
  localparam int SCALED_W = 32;   // rescaled product, |p| <= 2^30
  localparam int TERM_W   = 35;   // doubled sum of two rescaled products
  localparam int ACC_W    = 48;   // Q17.30 accumulator
  localparam int EXP_W    = 34;   // Q3.30 result
  localparam int OUT_TDATA_W = ((EXP_W + 7) / 8) * 8;

  // depth of the queue between the front and back parts
  localparam int QUEUE_DEPTH = 4;

  // op codes carried in the input tuser
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_EVAL = 1'b1;

  // status codes carried in the output tuser
  localparam logic STATUS_OK       = 1'b0;
  localparam logic STATUS_MASK_ERR = 1'b1;

  // classification of one queued transaction
  typedef struct packed {
    logic is_eval;    // evaluate, else load
    logic err;        // mask bit at or above the qubit count
    logic y_odd;      // odd number of Y qubits: use imaginary part
    logic neg_phase;  // bit 1 of the Y count: negate the pair terms
  } cls_t;

endpackage

>>> hdl/pauli_expectation_engine.sv
// Top level of the Pauli expectation engine: qubit-count register, front part,
// queue and back part. Depends on pee_pkg, pee_front, pee_queue and pee_back.
`timescale 1ns / 1ps

// Channel   Direction  Handshake                      Payload
// s_axis    in         s_axis_tvalid_i/tready_o       tdata: amp_index, amp_real, amp_imag,
//                                                     x_mask, y_mask, z_mask; tuser: op
// m_axis    out        m_axis_tvalid_o/tready_i       tdata: expectation; tuser: status
// cfg       in         cfg_valid_i/cfg_ready_o        cfg_data_i: num_qubits
//
// A load transaction writes the store when the back part pops it. An evaluate
// transaction walks the whole state vector, one amplitude pair read from the
// two-port store per cycle, then drains the pipeline and registers its result.
// A mask error skips the walk and leaves the accumulator. Reset clears control
// state and sets the qubit count to 10; the store holds no valid data until
// loaded. The front keeps taking transactions into the four-entry queue while
// the back walks or while a result waits in the output register; only a full
// queue stalls s_axis.

module pauli_expectation_engine #(
  parameter int MaxQubits = pee_pkg::MAX_QUBITS_DEF,
  parameter int AmpBits   = pee_pkg::AMP_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  // amp_index, amp_real, amp_imag, x_mask, y_mask, z_mask, zero fill
  input  logic [((4*MaxQubits+2*AmpBits+7)/8)*8-1:0] s_axis_tdata_i,
  // op
  input  logic [0:0]                        s_axis_tuser_i,
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  // expectation, zero fill
  output logic [pee_pkg::OUT_TDATA_W-1:0]   m_axis_tdata_o,
  // status
  output logic [0:0]                        m_axis_tuser_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  // num_qubits
  input  logic [pee_pkg::NUM_QUBITS_W-1:0]  cfg_data_i
);

  localparam int InW   = ((4 * MaxQubits + 2 * AmpBits + 7) / 8) * 8;
  localparam int PayW  = 3 * MaxQubits + 2 * AmpBits;
  localparam int ClsW  = $bits(pee_pkg::cls_t);
  localparam int NqW   = pee_pkg::NUM_QUBITS_W;
  localparam int NqRst = (pee_pkg::NUM_QUBITS_RST > MaxQubits) ? MaxQubits
                                                             : pee_pkg::NUM_QUBITS_RST;

  // qubit count; writes above the supported count clamp to it
  logic [NqW-1:0] num_qubits_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_qubits_q <= NqW'(NqRst);
    end else if (cfg_valid_i) begin
      num_qubits_q <= (int'(cfg_data_i) > MaxQubits) ? NqW'(MaxQubits) : cfg_data_i;
    end
  end

  // front: classify and pack
  logic            fq_valid, fq_ready;
  pee_pkg::cls_t   fq_cls;
  logic [PayW-1:0] fq_data;

  pee_front #(
    .MaxQubits (MaxQubits),
    .AmpBits   (AmpBits),
    .InW       (InW),
    .PayW      (PayW)
  ) u_front (
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .num_qubits_i    (num_qubits_q),
    .q_valid_o       (fq_valid),
    .q_ready_i       (fq_ready),
    .q_cls_o         (fq_cls),
    .q_data_o        (fq_data)
  );

  // queue: decouple the front from the walk
  logic                 bq_valid, bq_ready;
  logic [ClsW+PayW-1:0] bq_entry;
  pee_pkg::cls_t        bq_cls;
  logic [PayW-1:0]      bq_data;

  pee_queue #(
    .Width (ClsW + PayW),
    .Depth (pee_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (fq_valid),
    .wr_ready_o (fq_ready),
    .wr_data_i  ({fq_cls, fq_data}),
    .rd_valid_o (bq_valid),
    .rd_ready_i (bq_ready),
    .rd_data_o  (bq_entry)
  );

  assign bq_cls  = bq_entry[ClsW+PayW-1:PayW];
  assign bq_data = bq_entry[PayW-1:0];

  // back: store, walk, accumulate, hold the result
  pee_back #(
    .MaxQubits (MaxQubits),
    .AmpBits   (AmpBits),
    .PayW      (PayW)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .num_qubits_i    (num_qubits_q),
    .q_valid_i       (bq_valid),
    .q_ready_o       (bq_ready),
    .q_cls_i         (bq_cls),
    .q_data_i        (bq_data),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

endmodule

>>> hdl/pee_front.sv
// Front part: accept input transactions, classify them and pack the queue entry.
// Depends on pee_pkg.
`timescale 1ns / 1ps

module pee_front #(
  parameter int MaxQubits = pee_pkg::MAX_QUBITS_DEF,
  parameter int AmpBits   = pee_pkg::AMP_BITS_DEF,
  parameter int InW       = ((4 * MaxQubits + 2 * AmpBits + 7) / 8) * 8,
  parameter int PayW      = 3 * MaxQubits + 2 * AmpBits
) (
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  // amp_index, amp_real, amp_imag, x_mask, y_mask, z_mask, zero fill
  input  logic [InW-1:0]                    s_axis_tdata_i,
  // op
  input  logic [0:0]                        s_axis_tuser_i,
  input  logic [pee_pkg::NUM_QUBITS_W-1:0]  num_qubits_i,
  output logic                              q_valid_o,
  input  logic                              q_ready_i,
  output pee_pkg::cls_t                     q_cls_o,
  output logic [PayW-1:0]                   q_data_o
);

  localparam int QW = MaxQubits;
  localparam int A  = AmpBits;

  logic [QW-1:0] amp_index, x_mask, y_mask, z_mask, any_mask;
  logic [A-1:0]  amp_real, amp_imag;
  logic [pee_pkg::NUM_QUBITS_W:0] y_count;

  assign amp_index = s_axis_tdata_i[QW-1:0];
  assign amp_real  = s_axis_tdata_i[QW+A-1:QW];
  assign amp_imag  = s_axis_tdata_i[QW+2*A-1:QW+A];
  assign x_mask    = s_axis_tdata_i[2*QW+2*A-1:QW+2*A];
  assign y_mask    = s_axis_tdata_i[3*QW+2*A-1:2*QW+2*A];
  assign z_mask    = s_axis_tdata_i[4*QW+2*A-1:3*QW+2*A];

  assign any_mask = x_mask | y_mask | z_mask;
  assign y_count  = ($bits(y_count))'($countones(y_mask));

  always_comb begin
    q_cls_o.is_eval   = (s_axis_tuser_i[0] == pee_pkg::OP_EVAL);
    q_cls_o.err       = q_cls_o.is_eval && ((any_mask >> num_qubits_i) != '0);
    q_cls_o.y_odd     = y_count[0];
    q_cls_o.neg_phase = y_count[1];
  end

  // flip mask X|Y, sign mask Y|Z
  assign q_data_o = {y_mask | z_mask, x_mask | y_mask, amp_imag, amp_real, amp_index};

  assign q_valid_o       = s_axis_tvalid_i;
  assign s_axis_tready_o = q_ready_i;

endmodule

>>> hdl/pee_queue.sv
// Short first-in first-out queue between the front and back parts.
// Depends on no other file.
`timescale 1ns / 1ps

module pee_queue #(
  parameter int Width = 8,
  parameter int Depth = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_valid_i,
  output logic             wr_ready_o,
  input  logic [Width-1:0] wr_data_i,
  output logic             rd_valid_o,
  input  logic             rd_ready_i,
  output logic [Width-1:0] rd_data_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [PtrW:0]    count_q, count_d;
  logic             push, pop;

  assign wr_ready_o = (count_q != (PtrW+1)'(Depth));
  assign rd_valid_o = (count_q != '0);
  assign push       = wr_valid_i && wr_ready_o;
  assign pop        = rd_valid_o && rd_ready_i;
  assign rd_data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push && !pop) begin
      count_d = count_q + (PtrW+1)'(1);
    end else if (pop && !push) begin
      count_d = count_q - (PtrW+1)'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

>>> hdl/pee_back.sv
// Back part: amplitude store, pipelined pair walk, saturating accumulator
// and output register. Depends on pee_pkg.
`timescale 1ns / 1ps

module pee_back #(
  parameter int MaxQubits = pee_pkg::MAX_QUBITS_DEF,
  parameter int AmpBits   = pee_pkg::AMP_BITS_DEF,
  parameter int PayW      = 3 * MaxQubits + 2 * AmpBits
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic [pee_pkg::NUM_QUBITS_W-1:0]  num_qubits_i,
  input  logic                              q_valid_i,
  output logic                              q_ready_o,
  input  pee_pkg::cls_t                     q_cls_i,
  input  logic [PayW-1:0]                   q_data_i,
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  // expectation, zero fill
  output logic [pee_pkg::OUT_TDATA_W-1:0]   m_axis_tdata_o,
  // status
  output logic [0:0]                        m_axis_tuser_o
);

  localparam int QW     = MaxQubits;
  localparam int A      = AmpBits;
  localparam int Depth  = 1 << QW;
  localparam int FracIn = 2 * (A - 1);
  localparam int AccW   = pee_pkg::ACC_W;
  localparam int TermW  = pee_pkg::TERM_W;
  localparam int ScW    = pee_pkg::SCALED_W;
  localparam int ExpW   = pee_pkg::EXP_W;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_WALK  = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;
  localparam logic [1:0] ST_EMIT  = 2'd3;

  // queue entry fields
  logic [QW-1:0] ld_index, ev_flip, ev_yz;
  logic [2*A-1:0] ld_amp;
  assign ld_index = q_data_i[QW-1:0];
  assign ld_amp   = q_data_i[QW+2*A-1:QW];
  assign ev_flip  = q_data_i[2*QW+2*A-1:QW+2*A];
  assign ev_yz    = q_data_i[3*QW+2*A-1:2*QW+2*A];

  logic [1:0]    state_q, state_d;
  logic [QW-1:0] flip_q, yz_q, cnt_q, cnt_d;
  logic          flip_nz_q, odd_q, negph_q, err_q;
  logic          pop;

  assign q_ready_o = (state_q == ST_IDLE);
  assign pop       = q_valid_i && q_ready_o;

  // last basis index 2^n - 1
  logic [QW:0]   len_w;
  logic [QW-1:0] last_idx;
  assign len_w    = (QW+1)'(1) << num_qubits_i;
  assign last_idx = len_w[QW-1:0] - QW'(1);

  // issue stage
  logic [QW-1:0] addr_j;
  logic          iss_vld, iss_last, iss_skip, iss_neg, s_neg;
  assign addr_j   = cnt_q ^ flip_q;
  assign iss_vld  = (state_q == ST_WALK);
  assign iss_last = (cnt_q == last_idx);
  assign iss_skip = flip_nz_q && (addr_j <= cnt_q);
  assign s_neg    = ^(cnt_q & yz_q);
  assign iss_neg  = flip_nz_q ? (s_neg ^ negph_q) : s_neg;

  // amplitude store, two registered read ports
  logic [2*A-1:0] store_q [Depth];
  logic [2*A-1:0] rd_i_q, rd_j_q;

  always_ff @(posedge clk_i) begin
    if (pop && !q_cls_i.is_eval) begin
      store_q[ld_index] <= ld_amp;
    end
    rd_i_q <= store_q[cnt_q];
    rd_j_q <= store_q[addr_j];
  end

  logic s1_vld_q, s1_last_q, s1_skip_q, s1_neg_q;
  logic s2_vld_q, s2_last_q, s2_skip_q, s2_neg_q;
  logic s3_vld_q, s3_last_q, s3_skip_q, s3_neg_q;

  // multiply stage
  logic signed [A-1:0]   ri, ii, rj, ij, mul_b, mul_d;
  logic signed [2*A-1:0] prod_a_q, prod_b_q;
  assign ri    = $signed(rd_i_q[A-1:0]);
  assign ii    = $signed(rd_i_q[2*A-1:A]);
  assign rj    = $signed(rd_j_q[A-1:0]);
  assign ij    = $signed(rd_j_q[2*A-1:A]);
  assign mul_b = odd_q ? ij : rj;
  assign mul_d = odd_q ? rj : ij;

  always_ff @(posedge clk_i) begin
    prod_a_q <= ri * mul_b;
    prod_b_q <= ii * mul_d;
  end

  // bring both products to 30 fraction bits
  logic signed [ScW-1:0] sc_a, sc_b;
  if (FracIn >= pee_pkg::FRAC_OUT) begin : g_shr
    assign sc_a = ScW'(prod_a_q >>> (FracIn - pee_pkg::FRAC_OUT));
    assign sc_b = ScW'(prod_b_q >>> (FracIn - pee_pkg::FRAC_OUT));
  end else begin : g_shl
    assign sc_a = ScW'(prod_a_q) <<< (pee_pkg::FRAC_OUT - FracIn);
    assign sc_b = ScW'(prod_b_q) <<< (pee_pkg::FRAC_OUT - FracIn);
  end

  // term stage: real part sums, imaginary part subtracts, pairs double
  logic signed [TermW-1:0] term_sum, term_q;
  assign term_sum = odd_q ? (TermW'(sc_a) - TermW'(sc_b)) : (TermW'(sc_a) + TermW'(sc_b));

  always_ff @(posedge clk_i) begin
    term_q <= flip_nz_q ? (term_sum <<< 1) : term_sum;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= iss_vld;
      s2_vld_q <= s1_vld_q;
      s3_vld_q <= s2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_last_q <= iss_last;
    s1_skip_q <= iss_skip;
    s1_neg_q  <= iss_neg;
    s2_last_q <= s1_last_q;
    s2_skip_q <= s1_skip_q;
    s2_neg_q  <= s1_neg_q;
    s3_last_q <= s2_last_q;
    s3_skip_q <= s2_skip_q;
    s3_neg_q  <= s2_neg_q;
  end

  // saturating accumulate
  logic signed [AccW-1:0] acc_q, acc_sat;
  logic signed [AccW:0]   acc_sum;
  assign acc_sum = s3_neg_q ? ((AccW+1)'(acc_q) - (AccW+1)'(term_q))
                            : ((AccW+1)'(acc_q) + (AccW+1)'(term_q));

  always_comb begin
    if (acc_sum[AccW] != acc_sum[AccW-1]) begin
      acc_sat = acc_sum[AccW] ? {1'b1, {(AccW-1){1'b0}}} : {1'b0, {(AccW-1){1'b1}}};
    end else begin
      acc_sat = acc_sum[AccW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else if (pop && q_cls_i.is_eval && !q_cls_i.err) begin
      acc_q <= '0;
    end else if (s3_vld_q && !s3_skip_q) begin
      acc_q <= acc_sat;
    end
  end

  // result saturated to Q3.30
  logic [AccW-ExpW:0]    acc_hi;
  logic signed [ExpW-1:0] exp_sat;
  assign acc_hi = acc_q[AccW-1:ExpW-1];

  always_comb begin
    if ((&acc_hi) || !(|acc_hi)) begin
      exp_sat = acc_q[ExpW-1:0];
    end else begin
      exp_sat = acc_q[AccW-1] ? {1'b1, {(ExpW-1){1'b0}}} : {1'b0, {(ExpW-1){1'b1}}};
    end
  end

  // sequencer
  logic out_load;
  assign out_load = (state_q == ST_EMIT) && (!m_axis_tvalid_o || m_axis_tready_i);

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      ST_IDLE: begin
        cnt_d = '0;
        if (pop && q_cls_i.is_eval) begin
          state_d = q_cls_i.err ? ST_EMIT : ST_WALK;
        end
      end
      ST_WALK: begin
        if (iss_last) begin
          state_d = ST_DRAIN;
        end else begin
          cnt_d = cnt_q + QW'(1);
        end
      end
      ST_DRAIN: begin
        if (s3_vld_q && s3_last_q) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop && q_cls_i.is_eval) begin
      flip_q    <= ev_flip;
      yz_q      <= ev_yz;
      flip_nz_q <= (ev_flip != '0);
      odd_q     <= q_cls_i.y_odd;
      negph_q   <= q_cls_i.neg_phase;
      err_q     <= q_cls_i.err;
    end
  end

  // output register
  logic                  out_vld_q;
  logic [ExpW-1:0]       out_exp_q;
  logic                  out_status_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_load) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_exp_q    <= err_q ? '0 : exp_sat;
      out_status_q <= err_q ? pee_pkg::STATUS_MASK_ERR : pee_pkg::STATUS_OK;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = pee_pkg::OUT_TDATA_W'(out_exp_q);
  assign m_axis_tuser_o  = out_status_q;

endmodule

>>> verif/pee_checker.sv
// Checker for the Pauli expectation engine: watches the cfg, s_axis and m_axis
// channels, predicts every result and compares it. Depends on pee_pkg.
`timescale 1ns / 1ps

module pee_checker
  import pee_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     s_valid_i,
  input  logic                     s_ready_i,
  // amp_index, amp_real, amp_imag, x_mask, y_mask, z_mask
  input  logic [71:0]              s_data_i,
  // op
  input  logic [0:0]               s_user_i,
  input  logic                     m_valid_i,
  input  logic                     m_ready_i,
  // expectation, zero fill
  input  logic [OUT_TDATA_W-1:0]   m_data_i,
  // status
  input  logic [0:0]               m_user_i,
  input  logic                     cfg_valid_i,
  input  logic                     cfg_ready_i,
  input  logic [NUM_QUBITS_W-1:0]  cfg_data_i,
  output int                       mismatches_o,
  output int                       outstanding_o,
  output int                       checked_o
);

  localparam longint AccMax = (longint'(1) <<< 47) - 1;
  localparam longint AccMin = -AccMax - 1;
  localparam longint OutMax = (longint'(1) <<< 33) - 1;
  localparam longint OutMin = -OutMax - 1;

  typedef struct packed {
    logic [EXP_W-1:0] value;
    logic             status;
  } pauli_result_t;

  logic signed [15:0] amp_re [1024];
  logic signed [15:0] amp_im [1024];
  int                 qubits;
  pauli_result_t      predicted_q [$];
  int                 mismatches;
  int                 checked;

  assign mismatches_o  = mismatches;
  assign outstanding_o = predicted_q.size();
  assign checked_o     = checked;

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("MISMATCH %s: got %h, want %h at %0t ns", what, got, want, $time);
    mismatches++;
  endtask

  // Expectation of one Pauli string over the first 2^qubits stored amplitudes.
  // With 16-bit parts each product already carries 30 fraction bits.
  function automatic pauli_result_t predict_expectation(logic [9:0] xm, logic [9:0] ym,
                                                        logic [9:0] zm);
    pauli_result_t r;
    logic [9:0]    flip;
    logic [9:0]    yz;
    logic [9:0]    iv;
    int            ny;
    logic          y_odd;
    logic          neg_phase;
    logic          s_neg;
    int            len;
    int            j;
    longint        acc;
    longint        t;
    longint        ri, ii, rj, ij;
    if (((xm | ym | zm) >> qubits) != 0) begin
      r.value  = '0;
      r.status = STATUS_MASK_ERR;
      return r;
    end
    flip      = xm | ym;
    yz        = ym | zm;
    ny        = $countones(ym);
    y_odd     = ny[0];
    neg_phase = ny[1];
    len       = 1 << qubits;
    acc       = 0;
    for (int i = 0; i < len; i++) begin
      iv    = i[9:0];
      ri    = longint'(amp_re[i]);
      ii    = longint'(amp_im[i]);
      s_neg = ^(iv & yz);
      if (flip == '0) begin
        t = ri * ri + ii * ii;
        if (s_neg) t = -t;
      end else begin
        j = int'(iv ^ flip);
        if (j <= i || j >= len) continue;
        rj = longint'(amp_re[j]);
        ij = longint'(amp_im[j]);
        if (!y_odd) t = ri * rj + ii * ij;
        else        t = ri * ij - ii * rj;
        t = t * 2;
        if (s_neg != neg_phase) t = -t;
      end
      acc = acc + t;
      if (acc > AccMax) acc = AccMax;
      if (acc < AccMin) acc = AccMin;
    end
    if (acc > OutMax) acc = OutMax;
    if (acc < OutMin) acc = OutMin;
    r.value  = acc[EXP_W-1:0];
    r.status = STATUS_OK;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    pauli_result_t got;
    pauli_result_t want;
    if (!rst_ni) begin
      qubits     = NUM_QUBITS_RST;
      mismatches = 0;
      checked    = 0;
      predicted_q.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        qubits = (int'(cfg_data_i) > MAX_QUBITS_DEF) ? MAX_QUBITS_DEF : int'(cfg_data_i);
      end
      if (s_valid_i && s_ready_i) begin
        if (s_user_i[0] == OP_EVAL) begin
          predicted_q.push_back(predict_expectation(s_data_i[51:42], s_data_i[61:52],
                                                    s_data_i[71:62]));
        end else begin
          amp_re[s_data_i[9:0]] = s_data_i[25:10];
          amp_im[s_data_i[9:0]] = s_data_i[41:26];
        end
      end
      if (m_valid_i && m_ready_i) begin
        got.value  = m_data_i[EXP_W-1:0];
        got.status = m_user_i[0];
        if (predicted_q.size() == 0) begin
          report_mismatch("result with nothing outstanding", 64'(got), '0);
        end else begin
          want = predicted_q.pop_front();
          checked++;
          if (got.value !== want.value)
            report_mismatch("expectation", 64'(got.value), 64'(want.value));
          if (got.status !== want.status)
            report_mismatch("status", 64'(got.status), 64'(want.status));
        end
      end
    end
  end

endmodule

>>> verif/pauli_expectation_engine_tb.sv
// Testbench top of the Pauli expectation engine: clock, reset, stimulus and
// verdict. Depends on pee_pkg, pee_checker and the engine under hdl/.
`timescale 1ns / 1ps

module pauli_expectation_engine_tb;
  import pee_pkg::*;

  localparam int IN_W = ((4 * MAX_QUBITS_DEF + 2 * AMP_BITS_DEF + 7) / 8) * 8;

  logic                    clk_i;
  logic                    rst_ni;
  logic                    s_axis_tvalid_i;
  logic                    s_axis_tready_o;
  logic [IN_W-1:0]         s_axis_tdata_i;
  logic [0:0]              s_axis_tuser_i;
  logic                    m_axis_tvalid_o;
  logic                    m_axis_tready_i;
  logic [OUT_TDATA_W-1:0]  m_axis_tdata_o;
  logic [0:0]              m_axis_tuser_o;
  logic                    cfg_valid_i;
  logic                    cfg_ready_o;
  logic [NUM_QUBITS_W-1:0] cfg_data_i;

  int mismatches;
  int outstanding;
  int checked;

  // stimulus bookkeeping
  int   qubits_now;   // qubit count the block currently holds
  int   sent;         // accepted input transactions
  int   settings;     // qubit-count writes
  logic quiet;        // suppress idling on both sides

  pauli_expectation_engine dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_data_i      (cfg_data_i)
  );

  pee_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_valid_i     (s_axis_tvalid_i),
    .s_ready_i     (s_axis_tready_o),
    .s_data_i      (s_axis_tdata_i),
    .s_user_i      (s_axis_tuser_i),
    .m_valid_i     (m_axis_tvalid_o),
    .m_ready_i     (m_axis_tready_i),
    .m_data_i      (m_axis_tdata_o),
    .m_user_i      (m_axis_tuser_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_i   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .mismatches_o  (mismatches),
    .outstanding_o (outstanding),
    .checked_o     (checked)
  );

  // 20 ns period: low half, then high half
  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  // Hard limit: far above the slowest correct run.
  initial begin
    #20_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  // Result side: drop tready in random bursts, hold it high when quiet.
  initial begin
    m_axis_tready_i = 1'b1;
    forever begin
      @(negedge clk_i);
      if (!quiet && $urandom_range(0, 3) == 0) begin
        m_axis_tready_i = 1'b0;
        repeat ($urandom_range(1, 5)) @(negedge clk_i);
        m_axis_tready_i = 1'b1;
      end
    end
  end

  // Pack fields into tdata, amp_index in the lowest bits.
  function automatic logic [IN_W-1:0] pack_item(logic [9:0] idx, logic [15:0] re,
                                                logic [15:0] im, logic [9:0] xm,
                                                logic [9:0] ym, logic [9:0] zm);
    return {zm, ym, xm, im, re, idx};
  endfunction

  // Drive one transaction starting at a falling edge; return at the falling edge
  // after it was taken. Insert a random idle burst first unless quiet.
  task automatic send_txn(logic op, logic [IN_W-1:0] data);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid_i = 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk_i);
    end
    s_axis_tvalid_i = 1'b1;
    s_axis_tuser_i  = op;
    s_axis_tdata_i  = data;
    do @(posedge clk_i); while (!s_axis_tready_o);
    @(negedge clk_i);
    sent++;
  endtask

  // Load one amplitude; fill the unused mask fields with noise.
  task automatic load_amp(logic [9:0] idx, logic [15:0] re, logic [15:0] im);
    send_txn(OP_LOAD, pack_item(idx, re, im, 10'($urandom), 10'($urandom), 10'($urandom)));
  endtask

  // Evaluate one Pauli string; fill the unused amplitude fields with noise.
  task automatic eval_pauli(logic [9:0] xm, logic [9:0] ym, logic [9:0] zm);
    send_txn(OP_EVAL, pack_item(10'($urandom), 16'($urandom), 16'($urandom), xm, ym, zm));
  endtask

  // Hold the sender until every predicted result is out, then let queued loads
  // drain through the back part before anything else happens.
  task automatic wait_drained();
    s_axis_tvalid_i = 1'b0;
    while (outstanding != 0) @(negedge clk_i);
    repeat (32) @(negedge clk_i);
  endtask

  // Write the qubit count while the block is idle.
  task automatic set_qubits(logic [NUM_QUBITS_W-1:0] value);
    wait_drained();
    cfg_valid_i = 1'b1;
    cfg_data_i  = value;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
    qubits_now  = (int'(value) > MAX_QUBITS_DEF) ? MAX_QUBITS_DEF : int'(value);
    settings++;
  endtask

  // Amplitude part: mostly random, sometimes an extreme.
  function automatic logic [15:0] rand_part();
    case ($urandom_range(0, 19))
      0:       return 16'h8000;
      1:       return 16'h7fff;
      2:       return 16'h0000;
      3:       return 16'hffff;
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    int          phase_n [16] = '{1, 3, 2, 5, 0, 8, 6, 1, 4, 7, 7, 2, 3, 8, 1, 5};
    logic [9:0]  lane_mask;
    logic [9:0]  xm, ym, zm;
    int          eval_pct;

    quiet           = 1'b0;
    sent            = 0;
    settings        = 0;
    qubits_now      = NUM_QUBITS_RST;
    rst_ni          = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tuser_i  = OP_LOAD;
    s_axis_tdata_i  = '0;
    cfg_valid_i     = 1'b0;
    cfg_data_i      = '0;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Fill the first 256 entries so no later evaluate at up to eight qubits
    // reads an unwritten entry. Put the extremes on the first entries.
    load_amp(10'd0, 16'h7fff, 16'h8000);
    load_amp(10'd1, 16'h8000, 16'h7fff);
    for (int i = 2; i < 256; i++) load_amp(10'(i), rand_part(), rand_part());

    // Eight qubits: identity, all-X, Y/Z on every qubit, overlapping masks.
    set_qubits(4'd8);
    eval_pauli(10'h000, 10'h000, 10'h000);
    eval_pauli(10'h0ff, 10'h000, 10'h000);
    eval_pauli(10'h000, 10'h0ff, 10'h0ff);
    eval_pauli(10'h055, 10'h055, 10'h055);

    // Four qubits: odd entries at full negative scale, even entries zero, so
    // identity saturates high and Z on qubit 0 saturates low.
    set_qubits(4'd4);
    for (int i = 0; i < 16; i++) begin
      if (i % 2 == 1) load_amp(10'(i), 16'h8000, 16'h8000);
      else            load_amp(10'(i), 16'h0000, 16'h0000);
    end
    eval_pauli(10'h000, 10'h000, 10'h000);
    eval_pauli(10'h000, 10'h000, 10'h001);
    eval_pauli(10'h000, 10'h001, 10'h000);  // single Y: imaginary part
    eval_pauli(10'h003, 10'h000, 10'h000);
    eval_pauli(10'h000, 10'h003, 10'h000);  // two Y: negated phase
    eval_pauli(10'h005, 10'h005, 10'h005);
    eval_pauli(10'h000, 10'h000, 10'h010);  // mask beyond the qubit count
    eval_pauli(10'h3ff, 10'h000, 10'h000);

    // Zero qubits: a single amplitude; any mask bit is out of range.
    set_qubits(4'd0);
    eval_pauli(10'h000, 10'h000, 10'h000);
    eval_pauli(10'h001, 10'h000, 10'h000);
    load_amp(10'h3ff, rand_part(), rand_part());  // index beyond 2^n

    // A count above the maximum saturates to ten; load near the top of the store.
    set_qubits(4'd15);
    load_amp(10'h3a5, rand_part(), rand_part());

    set_qubits(4'd1);
    eval_pauli(10'h001, 10'h000, 10'h000);
    eval_pauli(10'h000, 10'h001, 10'h000);
    eval_pauli(10'h000, 10'h000, 10'h001);

    // Random phases, one qubit count each. Every count change also holds the
    // sender until all outstanding results have come. Keep evaluates rare at
    // large counts, where each one walks hundreds of amplitudes.
    for (int p = 0; p < 16; p++) begin
      set_qubits(4'(phase_n[p]));
      if (p >= 14) quiet = 1'b1;
      lane_mask = 10'((1 << qubits_now) - 1);
      eval_pct  = (qubits_now >= 8) ? 8 : 40;
      for (int k = 0; k < 18; k++) begin
        if ($urandom_range(0, 99) < eval_pct) begin
          if ($urandom_range(0, 99) < 15) begin
            // noise masks: mostly out of range at small counts
            xm = 10'($urandom);
            ym = 10'($urandom);
            zm = 10'($urandom);
          end else begin
            xm = 10'($urandom) & lane_mask;
            ym = 10'($urandom) & lane_mask;
            zm = 10'($urandom) & lane_mask;
            if ($urandom_range(0, 4) == 0) begin
              xm = '0;
              ym = '0;
            end
          end
          eval_pauli(xm, ym, zm);
        end else if ($urandom_range(0, 99) < 15) begin
          load_amp(10'($urandom), rand_part(), rand_part());
        end else begin
          load_amp(10'($urandom) & lane_mask, rand_part(), rand_part());
        end
      end
    end

    // Drain: wait for every result, then allow the back part to settle.
    s_axis_tvalid_i = 1'b0;
    while (outstanding != 0) @(negedge clk_i);
    repeat (64) @(negedge clk_i);

    $display("Covered %0d input transactions and %0d checked results", sent, checked);
    $display("over %0d qubit-count settings from zero up to the saturated maximum", settings);
    if (mismatches == 0 && outstanding == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

>>> files.f
hdl/pee_pkg.sv
hdl/pee_front.sv
hdl/pee_queue.sv
hdl/pee_back.sv
hdl/pauli_expectation_engine.sv
verif/pee_checker.sv
verif/pauli_expectation_engine_tb.sv
